@@ hw/rtl/svn_pkg.sv @@
package svn_pkg;

  localparam int IDX_W = 12;
  localparam int POS_W = 32;
  localparam int NRM_W = 16;

  // Request codes
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_TRI   = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Fraction bits of the unit vector: face normals and read results
  localparam int FRAC_FACE = 16;
  localparam int FRAC_READ = 15;

  // Quotient bits of the scaling divide (quotient stays below 2^17)
  localparam int QBITS = 18;

endpackage

@@ hw/rtl/svn_in_if.sv @@
interface svn_in_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         req_type;
  logic [svn_pkg::IDX_W-1:0]          vertex_index;
  logic signed [svn_pkg::POS_W-1:0]   pos_x;
  logic signed [svn_pkg::POS_W-1:0]   pos_y;
  logic signed [svn_pkg::POS_W-1:0]   pos_z;
  logic [svn_pkg::IDX_W-1:0]          corner_a;
  logic [svn_pkg::IDX_W-1:0]          corner_b;
  logic [svn_pkg::IDX_W-1:0]          corner_c;

  modport source (output valid, req_type, vertex_index, pos_x, pos_y, pos_z,
                  corner_a, corner_b, corner_c, input ready);
  modport sink   (input valid, req_type, vertex_index, pos_x, pos_y, pos_z,
                  corner_a, corner_b, corner_c, output ready);
endinterface

@@ hw/rtl/svn_out_if.sv @@
interface svn_out_if;
  logic                               valid;
  logic                               ready;
  logic [svn_pkg::IDX_W-1:0]          result_index;
  logic signed [svn_pkg::NRM_W-1:0]   normal_x;
  logic signed [svn_pkg::NRM_W-1:0]   normal_y;
  logic signed [svn_pkg::NRM_W-1:0]   normal_z;
  logic                               used_default;

  modport source (output valid, result_index, normal_x, normal_y, normal_z,
                  used_default, input ready);
  modport sink   (input valid, result_index, normal_x, normal_y, normal_z,
                  used_default, output ready);
endinterface

@@ hw/rtl/svn_ram.sv @@
module svn_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hw/rtl/smooth_vertex_normals_unit.sv @@
// Smooth vertex normal unit. Items are write-position, add-triangle and
// read-normal requests; only a read returns an item. After reset the block
// clears the normal accumulators, one entry a cycle, before it takes its
// first item. Reads and triangles take a variable time: edge halving and the
// normalizing shifts set it, and a read of a zero accumulator or of an index
// past MAX_VERTICES, or a triangle with a zero cross product, ends early.
// All arithmetic runs through one 32x32 multiplier, a one-bit normalizing
// shifter, a 32-step square root and an 18-step restoring divider, and the
// triangle's corner reads and accumulator updates share the two memories.
// The block takes one item at a time; a finished result waits in an output
// register while the next item is accepted, and a read stalls only when
// that register is still full.
module smooth_vertex_normals_unit #(
  parameter int MAX_VERTICES = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  svn_in_if.sink     in_ch,
  svn_out_if.source  out_ch
);
  import svn_pkg::*;

  localparam int AW = $clog2(MAX_VERTICES);
  localparam logic [16:0] MAXV = 17'(MAX_VERTICES);
  localparam logic signed [32:0] LIM = 33'sd1073741824;
  localparam logic signed [32:0] NLIM = -33'sd1073741824;

  typedef enum logic [11:0] {
    S_CLR  = 12'b000000000001,
    S_IDLE = 12'b000000000010,
    S_PRD  = 12'b000000000100,
    S_SCL  = 12'b000000001000,
    S_CRS  = 12'b000000010000,
    S_ARD  = 12'b000000100000,
    S_NRM  = 12'b000001000000,
    S_SQ   = 12'b000010000000,
    S_SQRT = 12'b000100000000,
    S_DIV  = 12'b001000000000,
    S_ACC  = 12'b010000000000,
    S_OUT  = 12'b100000000000
  } state_t;

  state_t st_r;
  logic [AW-1:0] clr_r;
  logic [4:0] cnt_r;
  logic [1:0] ci_r;
  logic is_rd_r, dflt_r;
  logic [IDX_W-1:0] idx_r, ca_r, cb_r, cc_r;
  logic [95:0] pa_r;
  logic signed [32:0] e1_r [3];
  logic signed [32:0] e2_r [3];
  logic signed [63:0] prod_r;
  logic signed [63:0] cr_r [3];
  logic [2:0] neg_r;
  logic [61:0] m_r [3];
  logic [63:0] sum_r, sv_r, sr_r, sb_r;
  logic [31:0] len_r, rem_r;
  logic [QBITS-1:0] nsh_r, q_r;
  logic signed [18:0] fn_r [3];
  logic out_valid_r, out_dflt_r;
  logic [IDX_W-1:0] out_idx_r;
  logic signed [NRM_W-1:0] out_n_r [3];

  logic accept;
  logic pos_we, acc_we;
  logic [AW-1:0] pos_waddr, pos_raddr, acc_waddr, acc_raddr;
  logic [95:0] pos_rdata, acc_wdata, acc_rdata;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic [IDX_W-1:0] corner_sel;
  logic [61:0] orv;
  logic [47:0] num;
  logic [32:0] trial;
  logic ge;
  logic [QBITS-1:0] qn;
  logic [63:0] sq_try;
  logic [1:0] crs_sel;

  function automatic logic in_rng(input logic [IDX_W-1:0] i);
    return {5'b0, i} < MAXV;
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [18:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    if (s > 33'sd2147483647) return 32'sh7fffffff;
    if (s < -33'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  // Halve with truncation toward zero
  function automatic logic signed [32:0] halve(input logic signed [32:0] e);
    logic signed [32:0] t;
    t = e + (e[32] ? 33'sd1 : 33'sd0);
    return t >>> 1;
  endfunction

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (st_r == S_IDLE);
  assign prod = mul_a * mul_b;

  svn_ram #(.WIDTH(96), .DEPTH(MAX_VERTICES)) u_pos (
    .clk, .we(pos_we), .waddr(pos_waddr),
    .wdata({in_ch.pos_x, in_ch.pos_y, in_ch.pos_z}),
    .raddr(pos_raddr), .rdata(pos_rdata));

  svn_ram #(.WIDTH(96), .DEPTH(MAX_VERTICES)) u_acc (
    .clk, .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
    .raddr(acc_raddr), .rdata(acc_rdata));

  // Select the corner for position reads and accumulator updates
  always_comb begin
    case (st_r == S_PRD ? cnt_r[1:0] : ci_r)
      2'd0:    corner_sel = ca_r;
      2'd1:    corner_sel = cb_r;
      default: corner_sel = cc_r;
    endcase
  end

  // Memory port control
  always_comb begin
    pos_we    = accept && in_ch.req_type == REQ_WRITE && in_rng(in_ch.vertex_index);
    pos_waddr = AW'(in_ch.vertex_index);
    pos_raddr = AW'(corner_sel);
    acc_we    = 1'b0;
    acc_waddr = AW'(in_ch.vertex_index);
    acc_wdata = '0;
    acc_raddr = (st_r == S_ACC) ? AW'(corner_sel) : AW'(in_ch.vertex_index);
    if (st_r == S_CLR) begin
      acc_we    = 1'b1;
      acc_waddr = clr_r;
    end else if (pos_we) begin
      acc_we = 1'b1;
    end else if (st_r == S_ACC && cnt_r[0]) begin
      acc_we    = 1'b1;
      acc_waddr = AW'(corner_sel);
      acc_wdata = {sat_add(acc_rdata[95:64], fn_r[0]),
                   sat_add(acc_rdata[63:32], fn_r[1]),
                   sat_add(acc_rdata[31:0],  fn_r[2])};
    end
  end

  // Shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (st_r == S_CRS) begin
      case (cnt_r[2:0])
        3'd0:    begin mul_a = e1_r[1][31:0]; mul_b = e2_r[2][31:0]; end
        3'd1:    begin mul_a = e1_r[2][31:0]; mul_b = e2_r[1][31:0]; end
        3'd2:    begin mul_a = e1_r[2][31:0]; mul_b = e2_r[0][31:0]; end
        3'd3:    begin mul_a = e1_r[0][31:0]; mul_b = e2_r[2][31:0]; end
        3'd4:    begin mul_a = e1_r[0][31:0]; mul_b = e2_r[1][31:0]; end
        3'd5:    begin mul_a = e1_r[1][31:0]; mul_b = e2_r[0][31:0]; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (st_r == S_SQ && cnt_r[1:0] != 2'd3) begin
      mul_a = {1'b0, m_r[cnt_r[1:0]][30:0]};
      mul_b = {1'b0, m_r[cnt_r[1:0]][30:0]};
    end
  end

  // Normalize test, square root step, divide step and cross product slot
  always_comb begin
    orv     = m_r[0] | m_r[1] | m_r[2];
    sq_try  = sr_r + sb_r;
    num     = (is_rd_r ? 48'({m_r[ci_r][30:0], 15'b0}) : 48'({m_r[ci_r][30:0], 16'b0}))
              + 48'(len_r[31:1]);
    trial   = {rem_r, nsh_r[QBITS-1]};
    ge      = trial >= {1'b0, len_r};
    qn      = {q_r[QBITS-2:0], ge};
    crs_sel = 2'((cnt_r - 5'd1) >> 1);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLR;
      clr_r       <= '0;
      cnt_r       <= '0;
      ci_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ch.ready && st_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(MAX_VERTICES - 1)) st_r <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            idx_r  <= in_ch.vertex_index;
            ca_r   <= in_ch.corner_a;
            cb_r   <= in_ch.corner_b;
            cc_r   <= in_ch.corner_c;
            cnt_r  <= '0;
            ci_r   <= '0;
            dflt_r <= 1'b0;
            if (in_ch.req_type == REQ_TRI) begin
              is_rd_r <= 1'b0;
              if (in_rng(in_ch.corner_a) && in_rng(in_ch.corner_b) &&
                  in_rng(in_ch.corner_c)) st_r <= S_PRD;
            end else if (in_ch.req_type == REQ_READ) begin
              is_rd_r <= 1'b1;
              if (in_rng(in_ch.vertex_index)) begin
                st_r <= S_ARD;
              end else begin
                dflt_r <= 1'b1;
                st_r   <= S_OUT;
              end
            end
          end
        end
        // Read three corners; form edges from the first
        S_PRD: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 5'd1) pa_r <= pos_rdata;
          for (int i = 0; i < 3; i++) begin
            if (cnt_r == 5'd2)
              e1_r[i] <= 33'(signed'(pa_r[95-32*i -: 32])) -
                         33'(signed'(pos_rdata[95-32*i -: 32]));
            if (cnt_r == 5'd3)
              e2_r[i] <= 33'(signed'(pa_r[95-32*i -: 32])) -
                         33'(signed'(pos_rdata[95-32*i -: 32]));
          end
          if (cnt_r == 5'd3) st_r <= S_SCL;
        end
        // Halve both edges until every component magnitude is below 2^30
        S_SCL: begin
          if (e1_r[0] >= LIM || e1_r[0] <= NLIM || e1_r[1] >= LIM || e1_r[1] <= NLIM ||
              e1_r[2] >= LIM || e1_r[2] <= NLIM || e2_r[0] >= LIM || e2_r[0] <= NLIM ||
              e2_r[1] >= LIM || e2_r[1] <= NLIM || e2_r[2] >= LIM || e2_r[2] <= NLIM) begin
            for (int i = 0; i < 3; i++) begin
              e1_r[i] <= halve(e1_r[i]);
              e2_r[i] <= halve(e2_r[i]);
            end
          end else begin
            cnt_r <= '0;
            st_r  <= S_CRS;
          end
        end
        // Cross product: six products, each registered before it is accumulated
        S_CRS: begin
          cnt_r  <= cnt_r + 1'b1;
          prod_r <= prod;
          if (cnt_r >= 5'd1 && cnt_r <= 5'd6) begin
            if (cnt_r[0]) cr_r[crs_sel] <= prod_r;
            else cr_r[crs_sel] <= cr_r[crs_sel] - prod_r;
          end
          if (cnt_r == 5'd7) begin
            for (int i = 0; i < 3; i++) begin
              neg_r[i] <= cr_r[i][63];
              m_r[i]   <= 62'(cr_r[i][63] ? -cr_r[i] : cr_r[i]);
            end
            st_r <= S_NRM;
          end
        end
        // Load the accumulator of the vertex being read
        S_ARD: begin
          for (int i = 0; i < 3; i++) begin
            neg_r[i] <= acc_rdata[95-32*i];
            m_r[i]   <= 62'(acc_rdata[95-32*i]
                            ? -33'(signed'(acc_rdata[95-32*i -: 32]))
                            :  33'(signed'(acc_rdata[95-32*i -: 32])));
          end
          st_r <= S_NRM;
        end
        // Shift until the largest magnitude lies in [2^30, 2^31)
        S_NRM: begin
          if (orv == '0) begin
            dflt_r <= 1'b1;
            st_r   <= is_rd_r ? S_OUT : S_IDLE;
          end else if (orv[61:31] != '0) begin
            for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] >> 1;
          end else if (!orv[30]) begin
            for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] << 1;
          end else begin
            cnt_r <= '0;
            sum_r <= '0;
            st_r  <= S_SQ;
          end
        end
        // Sum of squares
        S_SQ: begin
          cnt_r  <= cnt_r + 1'b1;
          prod_r <= prod;
          if (cnt_r != 5'd0) sum_r <= sum_r + 64'(prod_r);
          if (cnt_r == 5'd3) begin
            sv_r <= sum_r + 64'(prod_r);
            sr_r <= '0;
            sb_r <= 64'd1 << 62;
            st_r <= S_SQRT;
          end
        end
        // Integer square root, one result bit a cycle
        S_SQRT: begin
          if (sv_r >= sq_try) begin
            sv_r <= sv_r - sq_try;
            sr_r <= (sr_r >> 1) + sb_r;
          end else begin
            sr_r <= sr_r >> 1;
          end
          sb_r <= sb_r >> 2;
          if (sb_r == 64'd1) begin
            len_r <= (sv_r >= sq_try) ? 32'((sr_r >> 1) + sb_r) : 32'(sr_r >> 1);
            cnt_r <= '0;
            ci_r  <= '0;
            st_r  <= S_DIV;
          end
        end
        // Rounded divide of each scaled magnitude by the length
        S_DIV: begin
          if (cnt_r == 5'd0) begin
            rem_r <= 32'(num[47:QBITS]);
            nsh_r <= num[QBITS-1:0];
            q_r   <= '0;
            cnt_r <= 5'd1;
          end else begin
            rem_r <= ge ? 32'(trial - {1'b0, len_r}) : trial[31:0];
            nsh_r <= nsh_r << 1;
            q_r   <= qn;
            cnt_r <= cnt_r + 1'b1;
            if (cnt_r == 5'(QBITS)) begin
              fn_r[ci_r] <= neg_r[ci_r] ? -19'(signed'({1'b0, qn})) : 19'(signed'({1'b0, qn}));
              cnt_r <= '0;
              if (ci_r == 2'd2) begin
                ci_r <= '0;
                st_r <= is_rd_r ? S_OUT : S_ACC;
              end else begin
                ci_r <= ci_r + 1'b1;
              end
            end
          end
        end
        // Read-modify-write each corner accumulator
        S_ACC: begin
          cnt_r <= {4'b0, ~cnt_r[0]};
          if (cnt_r[0]) begin
            ci_r <= ci_r + 1'b1;
            if (ci_r == 2'd2) st_r <= S_IDLE;
          end
        end
        // Hand the result to the output register
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_idx_r   <= idx_r;
            out_dflt_r  <= dflt_r;
            for (int i = 0; i < 3; i++) begin
              if (dflt_r) out_n_r[i] <= (i == 2) ? 16'sd32767 : 16'sd0;
              else if (fn_r[i] > 19'sd32767) out_n_r[i] <= 16'sd32767;
              else if (fn_r[i] < -19'sd32768) out_n_r[i] <= -16'sd32768;
              else out_n_r[i] <= fn_r[i][15:0];
            end
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_index = out_idx_r;
  assign out_ch.normal_x     = out_n_r[0];
  assign out_ch.normal_y     = out_n_r[1];
  assign out_ch.normal_z     = out_n_r[2];
  assign out_ch.used_default = out_dflt_r;

endmodule
